/* src/mm_pkg.sv */
// ----------------------------------------------------------------------------
// mm_pkg
// shared types and constants of the row-at-a-time matrix multiplier
// ----------------------------------------------------------------------------
package mm_pkg;

  localparam int MAX_DIM_DEF   = 16;
  localparam int FRAC_BITS_DEF = 8;

  localparam int DIM_W   = 5;
  localparam int IDX_W   = 4;
  localparam int ELEM_W  = 16;
  localparam int PROD_W  = 32;
  localparam int ACC_W   = 40;
  localparam int RES_W   = 32;
  localparam int CFG_A_W = 2;

  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = 1;
  localparam int Q_CNT_W = 2;

  typedef enum logic [1:0] {
    KIND_LOAD_A = 2'd0,
    KIND_LOAD_B = 2'd1,
    KIND_ROW    = 2'd2
  } kind_t;

  typedef enum logic [CFG_A_W-1:0] {
    REG_A_ROWS = 2'd0,
    REG_A_COLS = 2'd1,
    REG_B_ROWS = 2'd2,
    REG_B_COLS = 2'd3
  } cfg_reg_t;

  typedef enum logic [1:0] {
    CMD_LOAD_A = 2'd0,
    CMD_LOAD_B = 2'd1,
    CMD_ROW    = 2'd2,
    CMD_ERR    = 2'd3
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t            op;
    logic [IDX_W-1:0]   row;
    logic [IDX_W-1:0]   col;
    logic [ELEM_W-1:0]  elem;
  } cmd_t;

  typedef struct packed {
    logic [DIM_W-1:0] a_rows;
    logic [DIM_W-1:0] a_cols;
    logic [DIM_W-1:0] b_rows;
    logic [DIM_W-1:0] b_cols;
  } dims_t;

endpackage

/* src/matrix_multiply.sv */
// ----------------------------------------------------------------------------
// matrix_multiply
// row-at-a-time fixed-point matrix multiplier, top level
// ----------------------------------------------------------------------------
// loads: a load request is registered in the queue, then written into its element store
// rows: the back end takes no new request from the queue until every result of the
//   current row is loaded, since each row uses the single multiply-accumulate unit
// each result passes through the store read, product, accumulator and result registers
// reset: dimension registers return to 1, queue and result register empty;
//   the element stores keep their contents and need no clearing pass
module matrix_multiply #(
  parameter int MAX_DIM   = mm_pkg::MAX_DIM_DEF,
  parameter int FRAC_BITS = mm_pkg::FRAC_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [mm_pkg::CFG_A_W-1:0]       cfg_index,
  input  logic [mm_pkg::DIM_W-1:0]         cfg_data,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [1:0]                       in_kind,
  input  logic [mm_pkg::IDX_W-1:0]         in_row_index,
  input  logic [mm_pkg::IDX_W-1:0]         in_col_index,
  input  logic signed [mm_pkg::ELEM_W-1:0] in_element,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic signed [mm_pkg::RES_W-1:0]  out_product,
  output logic [mm_pkg::IDX_W-1:0]         out_col,
  output logic                             out_error,
  output logic                             out_last
);

  mm_pkg::dims_t dims;
  mm_pkg::cmd_t  push_cmd, head_cmd;
  logic          q_push, q_pop, q_full, q_empty;

  mm_front #(
    .MAX_DIM (MAX_DIM)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_kind      (in_kind),
    .in_row_index (in_row_index),
    .in_col_index (in_col_index),
    .in_element   (in_element),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_cmd        (push_cmd),
    .dims         (dims)
  );

  mm_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .head     (head_cmd),
    .empty    (q_empty)
  );

  mm_back #(
    .MAX_DIM   (MAX_DIM),
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .dims        (dims),
    .q_cmd       (head_cmd),
    .q_empty     (q_empty),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_product (out_product),
    .out_col     (out_col),
    .out_error   (out_error),
    .out_last    (out_last)
  );

endmodule

/* src/mm_front.sv */
// ----------------------------------------------------------------------------
// mm_front
// configuration registers, request intake and classification
// ----------------------------------------------------------------------------
module mm_front #(
  parameter int MAX_DIM = mm_pkg::MAX_DIM_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [mm_pkg::CFG_A_W-1:0]    cfg_index,
  input  logic [mm_pkg::DIM_W-1:0]      cfg_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [1:0]                    in_kind,
  input  logic [mm_pkg::IDX_W-1:0]      in_row_index,
  input  logic [mm_pkg::IDX_W-1:0]      in_col_index,
  input  logic signed [mm_pkg::ELEM_W-1:0] in_element,
  input  logic                          q_full,
  output logic                          q_push,
  output mm_pkg::cmd_t                  q_cmd,
  output mm_pkg::dims_t                 dims
);

  localparam int DIM_CAP = (MAX_DIM < 16) ? MAX_DIM : 16;
  localparam logic [mm_pkg::DIM_W-1:0] CAP = mm_pkg::DIM_W'(DIM_CAP);

  logic [mm_pkg::DIM_W-1:0] a_rows_r, a_cols_r, b_rows_r, b_cols_r;
  logic [mm_pkg::DIM_W-1:0] ar, ac, br, bc;
  logic                     enq;
  logic                     row_err;
  mm_pkg::cmd_t             cmd;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_rows_r <= mm_pkg::DIM_W'(1);
      a_cols_r <= mm_pkg::DIM_W'(1);
      b_rows_r <= mm_pkg::DIM_W'(1);
      b_cols_r <= mm_pkg::DIM_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      case (mm_pkg::cfg_reg_t'(cfg_index))
        mm_pkg::REG_A_ROWS: a_rows_r <= cfg_data;
        mm_pkg::REG_A_COLS: a_cols_r <= cfg_data;
        mm_pkg::REG_B_ROWS: b_rows_r <= cfg_data;
        mm_pkg::REG_B_COLS: b_cols_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign ar = (a_rows_r < CAP) ? a_rows_r : CAP;
  assign ac = (a_cols_r < CAP) ? a_cols_r : CAP;
  assign br = (b_rows_r < CAP) ? b_rows_r : CAP;
  assign bc = (b_cols_r < CAP) ? b_cols_r : CAP;

  assign dims = '{a_rows: ar, a_cols: ac, b_rows: br, b_cols: bc};

  assign row_err = (ar == '0) || (ac == '0) || (br == '0) || (bc == '0) ||
                   (ac != br) || ({1'b0, in_row_index} >= ar);

  always_comb begin
    enq      = 1'b0;
    cmd.op   = mm_pkg::CMD_ERR;
    cmd.row  = in_row_index;
    cmd.col  = in_col_index;
    cmd.elem = in_element;
    case (mm_pkg::kind_t'(in_kind))
      mm_pkg::KIND_LOAD_A: begin
        cmd.op = mm_pkg::CMD_LOAD_A;
        enq    = ({1'b0, in_row_index} < ar) && ({1'b0, in_col_index} < ac);
      end
      mm_pkg::KIND_LOAD_B: begin
        cmd.op = mm_pkg::CMD_LOAD_B;
        enq    = ({1'b0, in_row_index} < br) && ({1'b0, in_col_index} < bc);
      end
      mm_pkg::KIND_ROW: begin
        cmd.op = row_err ? mm_pkg::CMD_ERR : mm_pkg::CMD_ROW;
        enq    = 1'b1;
      end
      default: enq = 1'b0;
    endcase
  end

  assign in_stall = q_full;
  assign q_push   = in_valid && !in_stall && enq;
  assign q_cmd    = cmd;

endmodule

/* src/mm_queue.sv */
// ----------------------------------------------------------------------------
// mm_queue
// short request queue between intake and execution
// ----------------------------------------------------------------------------
module mm_queue (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  mm_pkg::cmd_t push_cmd,
  output logic         full,
  input  logic         pop,
  output mm_pkg::cmd_t head,
  output logic         empty
);

  mm_pkg::cmd_t                 slot_r [mm_pkg::Q_DEPTH];
  logic [mm_pkg::Q_PTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [mm_pkg::Q_CNT_W-1:0]   cnt_r, cnt_nxt;
  logic                         do_push, do_pop;

  assign full    = (cnt_r == mm_pkg::Q_CNT_W'(mm_pkg::Q_DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = slot_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

/* src/mm_back.sv */
// ----------------------------------------------------------------------------
// mm_back
// element stores, multiply-accumulate sequencer and result register
// ----------------------------------------------------------------------------
module mm_back #(
  parameter int MAX_DIM   = mm_pkg::MAX_DIM_DEF,
  parameter int FRAC_BITS = mm_pkg::FRAC_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  mm_pkg::dims_t                    dims,
  input  mm_pkg::cmd_t                     q_cmd,
  input  logic                             q_empty,
  output logic                             q_pop,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic signed [mm_pkg::RES_W-1:0]  out_product,
  output logic [mm_pkg::IDX_W-1:0]         out_col,
  output logic                             out_error,
  output logic                             out_last
);

  localparam int DEPTH = MAX_DIM * MAX_DIM;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int PF    = 2 * FRAC_BITS;
  localparam int UP    = (PF <= 16) ? 16 - PF : 0;
  localparam int DN    = (PF > 16) ? PF - 16 : 1;
  localparam int WW    = mm_pkg::ACC_W + 17;

  localparam logic signed [WW-1:0] RND   = WW'(1) <<< (DN - 1);
  localparam logic signed [WW-1:0] SMAX  = WW'(32'sh7fffffff);
  localparam logic signed [WW-1:0] SMIN  = {{(WW-32){1'b1}}, 32'h80000000};

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_MAC   = 5'b00010,
    ST_DRAIN = 5'b00100,
    ST_CONV  = 5'b01000,
    ST_ERR   = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  logic [mm_pkg::ELEM_W-1:0]        left_mem  [DEPTH];
  logic [mm_pkg::ELEM_W-1:0]        right_mem [DEPTH];
  logic signed [mm_pkg::ELEM_W-1:0] left_rd_r, right_rd_r;
  logic signed [mm_pkg::PROD_W-1:0] prod_r;
  logic signed [mm_pkg::ACC_W-1:0]  acc_r;
  logic                             rd_v_r, prod_v_r;
  logic                             issue;
  logic                             acc_clr;

  logic [mm_pkg::IDX_W-1:0] row_r, row_nxt;
  logic [mm_pkg::IDX_W-1:0] k_r, k_nxt;
  logic [mm_pkg::IDX_W-1:0] j_r, j_nxt;

  logic [AW-1:0] wr_addr, left_ra, right_ra;
  logic          wr_left, wr_right;

  logic                             out_free;
  logic                             res_load;
  logic signed [mm_pkg::RES_W-1:0]  res_product;
  logic                             res_error;
  logic                             res_last;
  logic                             k_end, j_end;

  logic signed [WW-1:0] ext, scaled;
  logic signed [mm_pkg::RES_W-1:0] conv;

  logic                            out_valid_r;
  logic signed [mm_pkg::RES_W-1:0] out_product_r;
  logic [mm_pkg::IDX_W-1:0]        out_col_r;
  logic                            out_error_r;
  logic                            out_last_r;

  assign out_free = !out_valid_r || !out_stall;
  assign k_end    = ({1'b0, k_r} == dims.a_cols - 1'b1);
  assign j_end    = ({1'b0, j_r} == dims.b_cols - 1'b1);

  assign wr_addr  = AW'(32'(q_cmd.row) * MAX_DIM + 32'(q_cmd.col));
  assign left_ra  = AW'(32'(row_r) * MAX_DIM + 32'(k_r));
  assign right_ra = AW'(32'(k_r) * MAX_DIM + 32'(j_r));

  // sequencer
  always_comb begin
    state_nxt   = state_r;
    row_nxt     = row_r;
    k_nxt       = k_r;
    j_nxt       = j_r;
    q_pop       = 1'b0;
    wr_left     = 1'b0;
    wr_right    = 1'b0;
    issue       = 1'b0;
    acc_clr     = 1'b0;
    res_load    = 1'b0;
    res_product = conv;
    res_error   = 1'b0;
    res_last    = j_end;
    case (state_r)
      ST_IDLE: begin
        if (!q_empty) begin
          q_pop = 1'b1;
          case (q_cmd.op)
            mm_pkg::CMD_LOAD_A: wr_left  = 1'b1;
            mm_pkg::CMD_LOAD_B: wr_right = 1'b1;
            mm_pkg::CMD_ROW: begin
              row_nxt   = q_cmd.row;
              k_nxt     = '0;
              j_nxt     = '0;
              acc_clr   = 1'b1;
              state_nxt = ST_MAC;
            end
            default: state_nxt = ST_ERR;
          endcase
        end
      end
      ST_MAC: begin
        issue = 1'b1;
        if (k_end) begin
          state_nxt = ST_DRAIN;
        end else begin
          k_nxt = k_r + 1'b1;
        end
      end
      ST_DRAIN: begin
        if (!rd_v_r && !prod_v_r) begin
          state_nxt = ST_CONV;
        end
      end
      ST_CONV: begin
        if (out_free) begin
          res_load = 1'b1;
          if (j_end) begin
            state_nxt = ST_IDLE;
          end else begin
            j_nxt     = j_r + 1'b1;
            k_nxt     = '0;
            acc_clr   = 1'b1;
            state_nxt = ST_MAC;
          end
        end
      end
      ST_ERR: begin
        res_product = '0;
        res_error   = 1'b1;
        res_last    = 1'b1;
        if (out_free) begin
          res_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      row_r    <= '0;
      k_r      <= '0;
      j_r      <= '0;
      rd_v_r   <= 1'b0;
      prod_v_r <= 1'b0;
      acc_r    <= '0;
    end else begin
      state_r  <= state_nxt;
      row_r    <= row_nxt;
      k_r      <= k_nxt;
      j_r      <= j_nxt;
      rd_v_r   <= issue;
      prod_v_r <= rd_v_r;
      if (acc_clr) begin
        acc_r <= '0;
      end else if (prod_v_r) begin
        acc_r <= acc_r + mm_pkg::ACC_W'(prod_r);
      end
    end
  end

  // element stores
  always_ff @(posedge clk) begin
    if (wr_left) begin
      left_mem[wr_addr] <= q_cmd.elem;
    end
    left_rd_r <= left_mem[left_ra];
  end

  always_ff @(posedge clk) begin
    if (wr_right) begin
      right_mem[wr_addr] <= q_cmd.elem;
    end
    right_rd_r <= right_mem[right_ra];
  end

  always_ff @(posedge clk) begin
    prod_r <= left_rd_r * right_rd_r;
  end

  // scale to q16.16 and saturate
  always_comb begin
    ext = WW'(acc_r);
    if (PF <= 16) begin
      scaled = ext <<< UP;
    end else begin
      scaled = (ext + RND) >>> DN;
    end
    if (scaled > SMAX) begin
      conv = 32'sh7fffffff;
    end else if (scaled < SMIN) begin
      conv = 32'sh80000000;
    end else begin
      conv = scaled[mm_pkg::RES_W-1:0];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      out_product_r <= res_product;
      out_col_r     <= res_error ? '0 : j_r;
      out_error_r   <= res_error;
      out_last_r    <= res_last;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_product = out_product_r;
  assign out_col     = out_col_r;
  assign out_error   = out_error_r;
  assign out_last    = out_last_r;

`ifndef ASSERT_OFF
  a_conv_drained: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CONV) |-> (!rd_v_r && !prod_v_r))
    else $error("conversion started with products in flight");

  a_k_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MAC) |-> ({1'b0, k_r} < dims.a_cols))
    else $error("inner index beyond column count");

  a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_error_r) |-> ({1'b0, out_col_r} < dims.b_cols))
    else $error("result column beyond column count");

  a_err_shape: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_error_r) |-> (out_last_r && out_product_r == '0))
    else $error("malformed error result");

  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (res_load && res_last) |=> (state_r == ST_IDLE))
    else $error("sequencer kept running after last result");
`endif

endmodule
